// ===== hw/rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths and controller/datapath interface types of the sliding
// window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int CFG_W      = 7;   // window_size register width
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the incoming item
    logic retire;   // drop the front candidate
    logic pop;      // drop the back candidate
    logic append;   // push the held sample as the newest candidate
    logic finish;   // emit the result if the window is full, clear on last
  } swm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;          // no live candidates
    logic front_expired;  // front candidate has left the window
    logic back_smaller;   // back candidate is below the held sample
    logic window_full;    // enough samples seen to give a result
    logic out_busy;       // output register full and stalled
  } swm_status_t;

endpackage

// ===== hw/rtl/swm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cfg
// APB-style register port holding the window_size register.
// ----------------------------------------------------------------------------
module swm_cfg
  import swm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CFG_W-1:0]      window_size_o
);

  localparam logic             REG_WINDOW_SIZE = 1'b0;  // word select bit
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd1;

  logic [CFG_W-1:0] window_size_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RST;
    end else if (wr_en) begin
      window_size_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata        = (paddr[2] == REG_WINDOW_SIZE) ? APB_DATA_W'(window_size_q) : '0;
  assign window_size_o = window_size_q;

endmodule

// ===== hw/rtl/swm_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_dpath
// Candidate ring memory, ring pointers, sequence counters, compares and the
// output register of the sliding window maximum block.
// ----------------------------------------------------------------------------
module swm_dpath
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swm_cmd_t                       cmd_i,
  output swm_status_t                    status_o,
  input  logic [CFG_W-1:0]               window_size_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           last_sample_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] window_max_o,
  output logic                           last_result_o
);

  localparam int IW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int PW      = $clog2(POS_MOD);
  localparam int CW      = $clog2(WINDOW_MAX + 1);
  localparam int WW      = (CFG_W > CW) ? CFG_W : CW;
  localparam int EW      = SAMPLE_WIDTH + PW;

  localparam logic [IW-1:0] IDX_LAST = IW'(WINDOW_MAX - 1);
  localparam logic [PW-1:0] POS_LAST = PW'(POS_MOD - 1);

  logic [IW-1:0] head_q, head_d, tail_q, tail_d, back_addr;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] seen_q, seen_d, pos_q, pos_d;

  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           last_q;

  logic [EW-1:0] mem [WINDOW_MAX];
  logic [EW-1:0] rd_front_q, rd_back_q, wr_entry;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_max_q;
  logic                           out_last_q;

  logic [WW-1:0]                  ws_ext, win;
  logic [PW-1:0]                  front_pos;
  logic [PW:0]                    age;
  logic signed [SAMPLE_WIDTH-1:0] front_val, back_val;
  logic                           emit;

  // Effective window: zero counts as one, saturate at the ring depth
  assign ws_ext = WW'(window_size_i);
  always_comb begin
    if (ws_ext == '0) begin
      win = WW'(1);
    end else if (ws_ext > WW'(WINDOW_MAX)) begin
      win = WW'(WINDOW_MAX);
    end else begin
      win = ws_ext;
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    seen_d  = seen_q;
    pos_d   = pos_q;
    if (cmd_i.retire) begin
      head_d  = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (cmd_i.pop) begin
      tail_d  = (tail_q == '0) ? IDX_LAST : tail_q - 1'b1;
      count_d = count_q - 1'b1;
    end
    if (cmd_i.append) begin
      tail_d  = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
      pos_d   = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
      if (seen_q != POS_LAST) begin
        seen_d = seen_q + 1'b1;
      end
    end
    // end of sequence: drop every candidate and restart the counters
    if (cmd_i.finish && last_q) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
      seen_d  = '0;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      seen_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      seen_q  <= seen_d;
      pos_q   <= pos_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
      last_q   <= last_sample_i;
    end
    if (emit) begin
      out_max_q  <= front_val;
      out_last_q <= last_q;
    end
  end

  // Ring memory: read ports follow the next front and back, so the
  // registered data always matches the current pointers
  assign back_addr = (tail_d == '0) ? IDX_LAST : tail_d - 1'b1;
  assign wr_entry  = {sample_q, pos_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[tail_q] <= wr_entry;
    end
    rd_front_q <= (cmd_i.append && (tail_q == head_d))    ? wr_entry : mem[head_d];
    rd_back_q  <= (cmd_i.append && (tail_q == back_addr)) ? wr_entry : mem[back_addr];
  end

  assign front_pos = rd_front_q[PW-1:0];
  assign front_val = signed'(rd_front_q[EW-1:PW]);
  assign back_val  = signed'(rd_back_q[EW-1:PW]);

  // Age of the front candidate, modulo the position range
  always_comb begin
    if (pos_q >= front_pos) begin
      age = {1'b0, pos_q} - {1'b0, front_pos};
    end else begin
      age = {1'b0, pos_q} + (PW+1)'(POS_MOD) - {1'b0, front_pos};
    end
  end

  assign status_o.empty         = (count_q == '0);
  assign status_o.front_expired = (age >= win);
  assign status_o.back_smaller  = (back_val < sample_q);
  assign status_o.window_full   = (seen_q >= win);
  assign status_o.out_busy      = out_valid_q && out_stall_i;

  assign emit = cmd_i.finish && status_o.window_full;

  assign out_valid_o   = out_valid_q;
  assign window_max_o  = out_max_q;
  assign last_result_o = out_last_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= WINDOW_MAX)
    else $error("candidate count above ring depth");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.retire || cmd_i.pop) |-> (count_q != '0))
    else $error("candidate dropped from an empty ring");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !status_o.out_busy)
    else $error("result written over a stalled result");

  a_seq_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && last_q) |=> (count_q == '0 && seen_q == '0 && pos_q == '0))
    else $error("sequence state not cleared after last item");
`endif

endmodule

// ===== hw/rtl/swm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer of the sliding window maximum block: walks the candidate ring
// for each item and issues commands to the datapath.
// ----------------------------------------------------------------------------
module swm_ctrl
  import swm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  swm_status_t status_i,
  output swm_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RETIRE = 4'b0010,
    S_POP    = 4'b0100,
    S_EMIT   = 4'b1000
  } swm_state_e;

  swm_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RETIRE;
        end
      end
      S_RETIRE: begin
        if (!status_i.empty && status_i.front_expired) begin
          cmd_o.retire = 1'b1;
        end else begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        if (!status_i.empty && status_i.back_smaller) begin
          cmd_o.pop = 1'b1;
        end else begin
          cmd_o.append = 1'b1;
          state_d      = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold while a result is due and the output is still stalled
        if (!(status_i.window_full && status_i.out_busy)) begin
          cmd_o.finish = 1'b1;
          in_stall_o   = 1'b0;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = S_RETIRE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (state_q == S_IDLE || state_q == S_EMIT))
    else $error("item taken in the middle of a ring walk");

  a_single_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.retire, cmd_o.pop, cmd_o.append, cmd_o.finish}))
    else $error("more than one ring operation in a cycle");

  a_append_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.append |=> (state_q == S_EMIT))
    else $error("append not followed by result step");
`endif

endmodule

// ===== hw/rtl/sliding_window_maximum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum of the last window_size signed samples, kept as a
// monotonic candidate deque in a ring memory.
// ----------------------------------------------------------------------------
// Each item walks the candidate ring: candidates that have left the window
// are retired from the front, smaller candidates are dropped from the back
// and the held sample is appended; every item adds one candidate, so each
// candidate is dropped at most once. The walk is set by the ring memory:
// one candidate is checked and dropped per cycle through the registered
// front and back read ports. A new item is taken in the result cycle of the
// previous one, and a finished result waits in the output register without
// holding back the next item unless that item's result is due while the
// output is stalled. No result is given until window_size samples of the
// current sequence have arrived; an item with last_sample set closes the
// sequence and clears all candidates. The user must write window_size
// (register 0) only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [APB_ADDR_W-1:0]          paddr,
  input  logic [APB_DATA_W-1:0]          pwdata,
  output logic [APB_DATA_W-1:0]          prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           last_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] window_max_o,
  output logic                           last_result_o
);

  logic [CFG_W-1:0] window_size;
  swm_cmd_t         cmd;
  swm_status_t      status;

  swm_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .window_size_o (window_size)
  );

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swm_dpath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .window_size_i (window_size),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .window_max_o  (window_max_o),
    .last_result_o (last_result_o)
  );

endmodule

// ===== dv/sliding_window_maximum_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum_checker
// Watches the register port and both item channels of the sliding window
// maximum block. Keeps its own copy of the window register and candidate
// deque, works out the result each accepted sample is due to give, and
// compares every accepted result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module sliding_window_maximum_checker
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [APB_ADDR_W-1:0]          paddr,
  input  logic [APB_DATA_W-1:0]          pwdata,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           last_sample_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic signed [SAMPLE_WIDTH-1:0] window_max_i,
  input  logic                           last_result_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);

  localparam int IDX_W           = $clog2(WINDOW_MAX);
  localparam int POS_W           = $clog2(2 * WINDOW_MAX);
  localparam int REG_WINDOW_SIZE = 0;
  localparam int MISMATCH_SHOWN  = 10;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] peak;
    logic                           last;
  } window_result_t;

  logic signed [SAMPLE_WIDTH-1:0] cand_val [WINDOW_MAX];
  logic [POS_W-1:0]               cand_pos [WINDOW_MAX];
  logic [IDX_W-1:0]               head_idx;
  logic [IDX_W-1:0]               tail_idx;
  logic [POS_W-1:0]               cand_cnt;
  logic [POS_W-1:0]               seen_cnt;
  logic [POS_W-1:0]               pos_cnt;
  logic [CFG_W-1:0]               win_size;

  window_result_t expected_max_q[$];
  int             mismatches;
  int             checked;

  task automatic clear_sequence();
    head_idx = '0;
    tail_idx = '0;
    cand_cnt = '0;
    seen_cnt = '0;
    pos_cnt  = '0;
  endtask

  task automatic log_failure(input string msg);
    mismatches++;
    if (mismatches <= MISMATCH_SHOWN) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    window_result_t   want;
    logic [POS_W-1:0] age;
    logic [IDX_W-1:0] back;
    int unsigned      w;
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        cand_val[i] = '0;
        cand_pos[i] = '0;
      end
      clear_sequence();
      win_size = CFG_W'(1);
      expected_max_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      // results are compared before this edge's sample is taken in
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (expected_max_q.size() == 0) begin
          log_failure($sformatf("unexpected result window_max %0d last_result %0b",
                                window_max_i, last_result_i));
        end else begin
          want = expected_max_q[0];
          expected_max_q.delete(0);
          if (window_max_i !== want.peak || last_result_i !== want.last)
            log_failure($sformatf("result mismatch: expected %0d/%0b, got %0d/%0b",
                                  want.peak, want.last, window_max_i, last_result_i));
        end
      end

      if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_WINDOW_SIZE)
        win_size = pwdata[CFG_W-1:0];

      if (in_valid_i && !in_stall_i) begin
        w = (win_size == 0) ? 1 : (win_size > WINDOW_MAX) ? WINDOW_MAX : win_size;

        // retire candidates that have fallen out of the window
        age = pos_cnt - cand_pos[head_idx];
        while (cand_cnt != 0 && age >= w) begin
          head_idx = head_idx + 1'b1;
          cand_cnt = cand_cnt - 1'b1;
          age      = pos_cnt - cand_pos[head_idx];
        end

        // drop smaller candidates from the back; equal ones stay
        back = tail_idx - 1'b1;
        while (cand_cnt != 0 && cand_val[back] < sample_i) begin
          tail_idx = back;
          cand_cnt = cand_cnt - 1'b1;
          back     = tail_idx - 1'b1;
        end

        if (cand_cnt < WINDOW_MAX) begin
          cand_val[tail_idx] = sample_i;
          cand_pos[tail_idx] = pos_cnt;
          tail_idx           = tail_idx + 1'b1;
          cand_cnt           = cand_cnt + 1'b1;
        end

        pos_cnt = pos_cnt + 1'b1;
        if (seen_cnt < 2 * WINDOW_MAX - 1) seen_cnt = seen_cnt + 1'b1;

        if (seen_cnt >= w) begin
          want.peak = cand_val[head_idx];
          want.last = last_sample_i;
          expected_max_q.insert(expected_max_q.size(), want);
        end

        if (last_sample_i) clear_sequence();
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_max_q.size();
    checked_o    <= checked;
  end

endmodule

// ===== dv/sliding_window_maximum_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum_test
// Feeds signed sample sequences through the sliding window maximum block
// under a range of window settings, with random gaps on both channels, a
// long output hold-off and sequences left open across window changes. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sliding_window_maximum_test;
  import swm_pkg::*;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int ITEMS        = 1150;
  localparam int QUIET_CYCLES = 2 * WINDOW_MAX;

  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SIZE = APB_ADDR_W'(0);
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED    = APB_ADDR_W'(4);

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  typedef enum int {
    PAT_RANDOM,
    PAT_NARROW,
    PAT_RISING,
    PAT_FALLING,
    PAT_EXTREME
  } sample_pattern_e;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           psel          = 1'b0;
  logic                           penable       = 1'b0;
  logic                           pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]          paddr         = '0;
  logic [APB_DATA_W-1:0]          pwdata        = '0;
  logic [APB_DATA_W-1:0]          prdata;
  logic                           pready;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic signed [SAMPLE_WIDTH-1:0] sample_i      = '0;
  logic                           last_sample_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] window_max_o;
  logic                           last_result_o;

  int failures;
  int pending;
  int results_seen;
  int sent_count      = 0;
  int reg_writes      = 0;
  int out_hold_cycles = 0;
  bit in_idle         = 1'b0;
  bit out_idle        = 1'b0;

  sliding_window_maximum #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .last_sample_i(last_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_max_o (window_max_o),
    .last_result_o(last_result_o)
  );

  sliding_window_maximum_checker #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .sample_i     (sample_i),
    .last_sample_i(last_sample_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_max_i (window_max_o),
    .last_result_i(last_result_o),
    .fail_count_o (failures),
    .pending_o    (pending),
    .checked_o    (results_seen)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("run timed out with %0d results outstanding", pending);
    $display("sliding_window_maximum_test: errors");
    $finish;
  end

  // Result side: a random stall before each item, or a long hold-off on request
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      if (out_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (out_hold_cycles) @(posedge clk_i);
        out_hold_cycles = 0;
      end else begin
        gap = out_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic signed [SAMPLE_WIDTH-1:0] next_sample(
    input sample_pattern_e                pat,
    input logic signed [SAMPLE_WIDTH-1:0] prev
  );
    logic [31:0] rnd;
    rnd = $urandom;
    unique case (pat)
      PAT_NARROW:  return SAMPLE_WIDTH'($signed(rnd[2:0]));
      PAT_RISING:  return prev + SAMPLE_WIDTH'(rnd[3:0]);
      PAT_FALLING: return prev - SAMPLE_WIDTH'(rnd[3:0]);
      PAT_EXTREME: begin
        unique case (rnd[1:0])
          2'd0:    return SAMPLE_MIN;
          2'd1:    return SAMPLE_MAX;
          2'd2:    return '0;
          default: return '1;
        endcase
      end
      default:     return rnd[SAMPLE_WIDTH-1:0];
    endcase
  endfunction

  // Called at a clock edge; leaves valid high so a back-to-back item needs no toggle
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic l);
    int gap;
    gap = in_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    last_sample_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    sent_count++;
  endtask

  task automatic send_sequence(input int len, input bit close);
    sample_pattern_e                pat;
    logic signed [SAMPLE_WIDTH-1:0] s;
    logic [31:0]                    seed;
    pat  = sample_pattern_e'($urandom_range(0, 4));
    seed = $urandom;
    s    = seed[SAMPLE_WIDTH-1:0];
    for (int i = 0; i < len; i++) begin
      s = next_sample(pat, s);
      send_sample(s, close && (i == len - 1));
    end
  endtask

  // Hold the input until every due result is out, then let the block go quiet
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  initial begin
    int          win;
    int          eff;
    int          nseq;
    int          len;
    int          pick;
    logic [31:0] rnd;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_idle  = 1'b1;
    out_idle = 1'b1;

    // reset window of one: every sample is its own maximum
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    drain_results();

    // window of three: extremes, ties kept in the deque, then a short sequence
    write_reg(ADDR_WINDOW_SIZE, APB_DATA_W'(3));
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd8, 1'b1);
    drain_results();

    // a write to an unmapped address must leave the window alone
    write_reg(ADDR_UNMAPPED, APB_DATA_W'(1));
    send_sample(16'sd9, 1'b0);
    send_sample(-16'sd9, 1'b0);
    send_sample(16'sd9, 1'b1);
    send_sample(16'sd4, 1'b0);
    send_sample(16'sd2, 1'b0);
    drain_results();

    // shrink the window in the middle of an open sequence
    write_reg(ADDR_WINDOW_SIZE, APB_DATA_W'(1));
    send_sample(16'sd1, 1'b1);
    drain_results();

    // zero acts as one
    write_reg(ADDR_WINDOW_SIZE, APB_DATA_W'(0));
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b1);
    drain_results();

    // all ones saturates to the largest window; this sequence is too short
    write_reg(ADDR_WINDOW_SIZE, APB_DATA_W'(127));
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b0);
    send_sample(-16'sd3, 1'b1);
    drain_results();

    // back-pressure: hold the result side while the sender streams flat out
    write_reg(ADDR_WINDOW_SIZE, APB_DATA_W'(2));
    in_idle         = 1'b0;
    out_idle        = 1'b0;
    out_hold_cycles = 300;
    send_sequence(40, 1'b1);

    while (sent_count < ITEMS) begin
      in_idle  = ($urandom_range(0, 2) != 0);
      out_idle = ($urandom_range(0, 2) != 0);
      pick     = $urandom_range(0, 9);
      unique case (pick)
        0:       win = 0;
        1:       win = 1;
        2:       win = WINDOW_MAX;
        3:       win = $urandom_range(WINDOW_MAX + 1, 127);
        4:       win = $urandom_range(17, WINDOW_MAX - 1);
        default: win = $urandom_range(2, 16);
      endcase
      eff = (win == 0) ? 1 : (win > WINDOW_MAX) ? WINDOW_MAX : win;

      drain_results();
      rnd = $urandom;
      write_reg(ADDR_WINDOW_SIZE, {rnd[APB_DATA_W-1:CFG_W], CFG_W'(win)});
      if ($urandom_range(0, 7) == 0) write_reg(ADDR_UNMAPPED, $urandom);

      // large windows are slow, so give them a single sequence
      nseq = (eff > 16) ? 1 : $urandom_range(2, 6);
      repeat (nseq) begin
        if (sent_count >= ITEMS) break;
        pick = $urandom_range(0, 19);
        if (pick < 3)
          len = $urandom_range(1, eff);
        else if (pick < 5 && eff <= 16)
          len = $urandom_range(130, 170);
        else
          len = eff + $urandom_range(0, (eff > 16) ? 24 : 2 * eff + 4);
        // stop close to the item budget
        if (len > ITEMS - sent_count) len = ITEMS - sent_count;
        // about one sequence in four stays open into the next setting
        send_sequence(len, $urandom_range(0, 3) != 0);
      end
    end

    drain_results();
    $display("sent %0d samples across %0d register writes, compared %0d results",
             sent_count, reg_writes, results_seen);
    $display("windows from zero to over-range, long output hold-off, %0d failures, %0d missing",
             failures, pending);
    if (failures == 0 && pending == 0) begin
      $display("sliding_window_maximum_test: clean");
    end else begin
      $display("sliding_window_maximum_test: errors");
    end
    $finish;
  end

endmodule
